@@ hdl/font_access_to_jis_text_assert.svh @@
// Assertion macros for the text capture RTL.
// Files that check their own logic include this header; needs clk_i and rst_ni in scope.
`ifndef FONT_ACCESS_TO_JIS_TEXT_ASSERT_SVH
`define FONT_ACCESS_TO_JIS_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define FAJT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("font_access_to_jis_text: assertion failed");
// Checked on every clock edge, reset included.
`define FAJT_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("font_access_to_jis_text: reset assertion failed");
`else
`define FAJT_ASSERT(name, prop)
`define FAJT_ASSERT_RST(name, prop)
`endif
`endif

@@ hdl/fajt_pkg.sv @@
// Types and constants for the text capture block.
// No dependencies; used by fajt_decode, fajt_serial and the top level.
package fajt_pkg;

  localparam int unsigned MaxWords = 6;

  // escape sequence bytes
  localparam logic [7:0] Esc       = 8'h1B;
  localparam logic [7:0] ParenOpen = 8'h28;
  localparam logic [7:0] Dollar    = 8'h24;
  localparam logic [7:0] FinalB    = 8'h42;
  localparam logic [7:0] FinalI    = 8'h49;

  // character sets
  localparam logic [1:0] SetAscii = 2'd0;
  localparam logic [1:0] SetKana  = 2'd1;
  localparam logic [1:0] SetKanji = 2'd2;

  localparam logic [7:0]  Space    = 8'h20;
  localparam logic [7:0]  CtrlMax  = 8'h1F;
  localparam logic [7:0]  DelChar  = 8'h7F;
  localparam logic [6:0]  KanaMin  = 7'h21;
  localparam logic [6:0]  KanaMax  = 7'h5F;
  localparam logic [15:0] KanaRow  = 16'h7FFF;
  localparam logic [15:0] JisMin   = 16'h2121;
  localparam logic [15:0] JisMax   = 16'h7C7E;
  localparam logic [15:0] JisSpace = 16'h2121;
  localparam logic [6:0]  LoMin    = 7'h21;
  localparam logic [6:0]  LoMax    = 7'h7E;
  localparam int unsigned FlushMargin = 4096;

  // all words caused by one access, lowest index goes out first
  typedef struct packed {
    logic [MaxWords-1:0][7:0] bytes;
    logic [MaxWords-1:0]      flush;
    logic [2:0]               count;
  } burst_t;

endpackage

@@ hdl/fajt_decode.sv @@
// Input register, character classification and capture state.
// Depends on fajt_pkg; feeds a burst of up to six words to fajt_serial.
module fajt_decode import fajt_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [19:0]   rom_address_i,
  input  logic [15:0]   kana_code_i,
  output logic          burst_valid_o,
  input  logic          burst_ready_i,
  output burst_t        burst_o
);

  localparam logic [16:0] FlushLimit = 17'(BUFFER_SIZE - FlushMargin);

  logic        valid_q;
  logic [19:0] addr_q;
  logic [15:0] code_q;
  logic        space_q, space_d;
  logic [1:0]  set_q;
  logic [15:0] fill_q, fill_d;

  logic [15:0] row;
  logic [7:0]  ch;
  logic [6:0]  kana_k;
  logic [7:0]  jis_hi;
  logic [6:0]  jis_lo;
  logic [15:0] jis;
  logic        jis_ok;

  logic        emit, two, req, esc, full, mark, fire;
  logic [1:0]  tgt;
  logic [7:0]  intro, fin, p0, p1;
  logic [2:0]  ntext;
  logic [16:0] sum;

  assign row    = addr_q[19:4];
  assign ch     = row[7:0];
  assign kana_k = code_q[14:8];
  assign jis_hi = {1'b0, row[6:0]} + 8'h20;
  assign jis_lo = row[14:8];
  assign jis    = {jis_hi, 1'b0, jis_lo};
  assign jis_ok = (jis >= JisMin) && (jis <= JisMax) && (jis_lo >= LoMin) && (jis_lo <= LoMax);

  always_comb begin
    emit    = 1'b0;
    two     = 1'b0;
    req     = 1'b0;
    space_d = space_q;
    tgt     = SetAscii;
    intro   = ParenOpen;
    fin     = FinalB;
    p0      = ch;
    p1      = 8'd0;
    if (row[15]) begin
      if (ch <= CtrlMax || ch >= DelChar) begin
        space_d = 1'b1;
        req     = 1'b1;
      end else if (ch == Space && space_q) begin
        req = 1'b1;
      end else begin
        space_d = (ch == Space);
        emit    = 1'b1;
      end
    end else if (row == KanaRow) begin
      space_d = 1'b0;
      tgt     = SetKana;
      fin     = FinalI;
      p0      = {1'b0, kana_k};
      emit    = (kana_k >= KanaMin) && (kana_k <= KanaMax);
    end else if (!row[7]) begin
      // kanji rows with bit 7 set are ignored entirely
      tgt   = SetKanji;
      intro = Dollar;
      two   = 1'b1;
      p0    = {1'b0, jis_hi[6:0]};
      p1    = {1'b0, jis_lo};
      if (jis_ok) begin
        if (space_q && jis == JisSpace) begin
          req = 1'b1;
        end else begin
          space_d = (jis == JisSpace);
          emit    = 1'b1;
        end
      end else begin
        space_d = 1'b1;
        req     = 1'b1;
      end
    end
  end

  assign esc   = emit && (set_q != tgt);
  assign ntext = emit ? ((esc ? 3'd3 : 3'd0) + (two ? 3'd2 : 3'd1)) : 3'd0;
  assign sum   = {1'b0, fill_q} + {14'd0, ntext};
  assign full  = emit && (sum >= FlushLimit);
  // a marker only goes out when something is buffered
  assign mark  = (req || full) && (emit || fill_q != 16'd0);
  assign fill_d = mark ? 16'd0 : sum[15:0];

  always_comb begin
    burst_o.bytes = '0;
    burst_o.flush = '0;
    if (esc) begin
      burst_o.bytes[0] = Esc;
      burst_o.bytes[1] = intro;
      burst_o.bytes[2] = fin;
      burst_o.bytes[3] = p0;
      burst_o.bytes[4] = p1;
    end else begin
      burst_o.bytes[0] = p0;
      burst_o.bytes[1] = p1;
    end
    if (mark) begin
      burst_o.bytes[ntext] = 8'd0;
      burst_o.flush[ntext] = 1'b1;
    end
    burst_o.count = enable_i ? (ntext + {2'd0, mark}) : 3'd0;
  end

  assign burst_valid_o = valid_q && (burst_o.count != 3'd0);
  assign fire          = valid_q && ((burst_o.count == 3'd0) || burst_ready_i);
  assign in_ready_o    = !valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      space_q <= 1'b0;
      set_q   <= SetAscii;
      fill_q  <= 16'd0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (fire && enable_i) begin
        space_q <= space_d;
        fill_q  <= fill_d;
        if (emit) begin
          set_q <= tgt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q <= rom_address_i;
      code_q <= kana_code_i;
    end
  end

endmodule

@@ hdl/fajt_serial.sv @@
`include "font_access_to_jis_text_assert.svh"
// Burst register that hands out one word per output handshake.
// Depends on fajt_pkg; loaded from fajt_decode.
module fajt_serial import fajt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       burst_valid_i,
  output logic       burst_ready_o,
  input  burst_t     burst_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tuser_o,
  output logic       m_axis_tlast_o
);

  logic [MaxWords-1:0][7:0] bytes_q;
  logic [MaxWords-1:0]      flush_q;
  logic [2:0]               cnt_q;
  logic                     take, load;

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign take            = m_axis_tvalid_o && m_axis_tready_i;
  // next burst may land in the cycle the last word leaves
  assign burst_ready_o   = (cnt_q == 3'd0) || (take && cnt_q == 3'd1);
  assign load            = burst_valid_i && burst_ready_o;

  assign m_axis_tdata_o = bytes_q[0];
  assign m_axis_tuser_o = flush_q[0];
  assign m_axis_tlast_o = (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (load) begin
      cnt_q <= burst_i.count;
    end else if (take) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= burst_i.bytes;
      flush_q <= burst_i.flush;
    end else if (take) begin
      bytes_q <= bytes_q >> 8;
      flush_q <= flush_q >> 1;
    end
  end

  `FAJT_ASSERT(a_cnt_range, cnt_q <= 3'd6)
  `FAJT_ASSERT(a_load_nonempty, burst_valid_i |-> burst_i.count != 3'd0)
  `FAJT_ASSERT(a_flush_is_last, m_axis_tvalid_o && flush_q[0] |-> cnt_q == 3'd1)
  `FAJT_ASSERT(a_flush_zero, m_axis_tvalid_o && flush_q[0] |-> bytes_q[0] == 8'd0)
  `FAJT_ASSERT_RST(a_rst_empty, !rst_ni |=> !m_axis_tvalid_o)

endmodule

@@ hdl/font_access_to_jis_text.sv @@
// channel  | dir | handshake                  | word
// s_axis   | in  | s_axis_tvalid/tready       | tdata: rom_address[19:0], kana_code[35:20]
// m_axis   | out | m_axis_tvalid/tready       | tdata: out_byte; tuser: is_flush; tlast
// apb      | in  | psel & penable & pwrite    | reg 0 at 0x0: capture_enable (bit 0)
// An access is registered, decoded combinationally into up to six words, and those
// words leave one per cycle from the burst register in fajt_serial while tready is high.
// The burst register paces the input: a burst loads as the previous one's last word leaves.
// Reset clears capture_enable, the character set, the space flag and the fill count.
// A stalled output holds its burst; the input register still takes one more access.
// Top level of the text capture block; depends on fajt_pkg, fajt_decode, fajt_serial.
module font_access_to_jis_text import fajt_pkg::*; #(
  parameter int unsigned BUFFER_SIZE = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [19:0] rom_address, [35:20] kana_code, [39:36] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tuser_o,   // [0] is_flush
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic   enable_q;
  logic   burst_valid, burst_ready;
  burst_t burst;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == 1'b0) ? {31'd0, enable_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && pready_o && paddr_i[2] == 1'b0) begin
      enable_q <= pwdata_i[0];
    end
  end

  fajt_decode #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_decode (
    .clk_i,
    .rst_ni,
    .enable_i      (enable_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .rom_address_i (s_axis_tdata_i[19:0]),
    .kana_code_i   (s_axis_tdata_i[35:20]),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready),
    .burst_o       (burst)
  );

  fajt_serial u_serial (
    .clk_i,
    .rst_ni,
    .burst_valid_i   (burst_valid),
    .burst_ready_o   (burst_ready),
    .burst_i         (burst),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

endmodule
